// ----- hdl/lbpu_pkg.sv -----
// Shared types, constants and helper functions for the bitmap pixel unpacker.
`timescale 1ns / 1ps

package lbpu_pkg;

    // Default sizing
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int DIM_BITS_DEF      = 16;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int PIXEL_W    = 32;
    localparam int ENTRIES_W  = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W    = 2;
    localparam int PARTIAL_W  = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT    = 3'd0,
        CFG_ALPHA_PRESENT   = 3'd1,
        CFG_IMAGE_WIDTH     = 3'd2,
        CFG_IMAGE_HEIGHT    = 3'd3,
        CFG_PALETTE_ENTRIES = 3'd4
    } t_cfg_idx;

    // Pixel format codes
    typedef enum logic [1:0] {
        FMT_PALETTE = 2'd0,
        FMT_RGB555  = 2'd1,
        FMT_ARGB32  = 2'd2
    } t_fmt;

    // Item held between the lookup stage and the output register
    typedef struct packed {
        logic               use_ram;
        logic [PIXEL_W-1:0] argb;
        logic               last;
        logic               err;
    } t_stage;

    // Widen x:R5:G5:B5 to ARGB8888 by bit replication, alpha opaque
    function automatic logic [PIXEL_W-1:0] widen_555(input logic [14:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {c[14:10], c[14:12]};
        g = {c[9:5], c[9:7]};
        b = {c[4:0], c[4:2]};
        return {8'hff, r, g, b};
    endfunction

endpackage

// ----- hdl/lbpu_byte_if.sv -----
// Byte stream channel: valid/ready handshake with one data byte.
`timescale 1ns / 1ps

interface lbpu_byte_if;
    logic                       valid;
    logic                       ready;
    logic [lbpu_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- hdl/lbpu_pixel_if.sv -----
// Pixel channel: valid/ready handshake with one ARGB pixel and its flags.
`timescale 1ns / 1ps

interface lbpu_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [lbpu_pkg::PIXEL_W-1:0] pixel_argb;
    logic                        last_pixel;
    logic                        index_error;

    modport source (output valid, output pixel_argb, output last_pixel,
                    output index_error, input ready);
    modport sink   (input valid, input pixel_argb, input last_pixel,
                    input index_error, output ready);
endinterface

// ----- hdl/lbpu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lbpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lossless_bitmap_pixel_unpacker_top.sv -----
// Top level of the bitmap pixel unpacker: byte stream in, ARGB pixels out.
`timescale 1ns / 1ps
//
// Usage
//   i_byte  : inflated bitmap bytes, one item per valid/ready handshake.
//   o_pixel : one ARGB8888 pixel per item, with last_pixel on the final
//             pixel and index_error on an out-of-range palette index.
//   i_cfg_* : register writes (format, alpha, width, height, entries);
//             write only while no item is in flight.
// Throughput is one byte per cycle while the receiver does not stall. After
// the byte that completes it, a pixel passes the lookup stage with the
// palette RAM read and then the output register. Palette loading, row
// padding and partial words produce no pixel. The palette RAM has one write
// and one read port; each byte issues either a load or a lookup, never both.
// Reset clears all counters, the pipeline and the registers; the palette
// contents are undefined until loaded. After the last pixel, bytes are
// taken and dropped until the next reset.
// When the receiver stalls, the output register holds its pixel, the
// lookup stage holds its item and the RAM read data, and i_byte.ready
// drops once both are full.
//

module lossless_bitmap_pixel_unpacker_top #(
    parameter int PALETTE_DEPTH = lbpu_pkg::PALETTE_DEPTH_DEF,
    parameter int DIM_BITS      = lbpu_pkg::DIM_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lbpu_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [lbpu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    lbpu_byte_if.sink                       i_byte,
    lbpu_pixel_if.source                    o_pixel
);

    localparam int AW  = $clog2(PALETTE_DEPTH);
    localparam int LCW = $clog2(PALETTE_DEPTH + 1);
    localparam int EW  = lbpu_pkg::ENTRIES_W;
    localparam int PW  = lbpu_pkg::PIXEL_W;
    localparam int PRW = lbpu_pkg::PARTIAL_W;
    localparam logic [EW-1:0] ENT_MAX = EW'(PALETTE_DEPTH);

    // Configuration registers
    logic [1:0]                      r_cfg_fmt;
    logic                            r_cfg_alpha;
    logic [lbpu_pkg::CFG_DATA_W-1:0] r_cfg_width;
    logic [lbpu_pkg::CFG_DATA_W-1:0] r_cfg_height;
    logic [EW-1:0]                   r_cfg_entries;

    // Stream state
    logic [LCW-1:0]               r_load_cnt, n_load_cnt;
    logic [lbpu_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [PRW-1:0]               r_partial, n_partial;
    logic [DIM_BITS-1:0]          r_col, n_col;
    logic [DIM_BITS-1:0]          r_row, n_row;
    logic [1:0]                   r_pad, n_pad;
    logic                         r_done, n_done;

    // Pipeline
    logic              r_s1_valid;
    lbpu_pkg::t_stage  r_s1;
    lbpu_pkg::t_stage  s0_item;
    logic              s0_emit;
    logic              r_out_valid;
    logic [PW-1:0]     r_out_argb;
    logic              r_out_last;
    logic              r_out_err;

    // RAM access
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [PW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;

    logic in_accept;
    logic s1_adv;

    // Handshake: advance the lookup stage whenever the output can take it
    assign s1_adv       = !r_out_valid || o_pixel.ready;
    assign i_byte.ready = !r_s1_valid || s1_adv;
    assign in_accept    = i_byte.valid && i_byte.ready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fmt     <= lbpu_pkg::FMT_PALETTE;
            r_cfg_alpha   <= 1'b0;
            r_cfg_width   <= lbpu_pkg::CFG_DATA_W'(1);
            r_cfg_height  <= lbpu_pkg::CFG_DATA_W'(1);
            r_cfg_entries <= EW'(256);
        end else if (i_cfg_we) begin
            unique case (lbpu_pkg::t_cfg_idx'(i_cfg_addr))
                lbpu_pkg::CFG_PIXEL_FORMAT:    r_cfg_fmt     <= i_cfg_wdata[1:0];
                lbpu_pkg::CFG_ALPHA_PRESENT:   r_cfg_alpha   <= i_cfg_wdata[0];
                lbpu_pkg::CFG_IMAGE_WIDTH:     r_cfg_width   <= i_cfg_wdata;
                lbpu_pkg::CFG_IMAGE_HEIGHT:    r_cfg_height  <= i_cfg_wdata;
                lbpu_pkg::CFG_PALETTE_ENTRIES: r_cfg_entries <= i_cfg_wdata[EW-1:0];
                default: ;
            endcase
        end
    end

    // Decode one byte: update counters, issue the palette write or read
    always_comb begin
        logic [DIM_BITS-1:0] width_d;
        logic [DIM_BITS-1:0] height_d;
        logic [EW-1:0]       entries;
        logic [2:0]          need;
        logic [2:0]          phase_inc;
        logic                word_done;
        logic [PW-1:0]       full;
        logic                pix;
        logic [DIM_BITS-1:0] col_inc;
        logic [DIM_BITS:0]   row_inc;
        logic [7:0]          b;

        width_d   = r_cfg_width[DIM_BITS-1:0];
        height_d  = r_cfg_height[DIM_BITS-1:0];
        entries   = (r_cfg_entries > ENT_MAX) ? ENT_MAX : r_cfg_entries;
        b         = i_byte.data_byte;
        full      = {r_partial, b};
        phase_inc = {1'b0, r_phase} + 3'd1;
        pix       = 1'b0;
        need      = 3'd4;
        word_done = 1'b0;
        col_inc   = r_col + DIM_BITS'(1);
        row_inc   = {1'b0, r_row} + (DIM_BITS + 1)'(1);

        n_load_cnt = r_load_cnt;
        n_phase    = r_phase;
        n_partial  = r_partial;
        n_col      = r_col;
        n_row      = r_row;
        n_pad      = r_pad;
        n_done     = r_done;

        ram_we    = 1'b0;
        ram_waddr = r_load_cnt[AW-1:0];
        ram_wdata = r_cfg_alpha ? {b, r_partial} : {8'hff, r_partial[15:0], b};
        ram_re    = 1'b0;
        ram_raddr = b[AW-1:0];

        s0_emit         = 1'b0;
        s0_item.use_ram = 1'b0;
        s0_item.argb    = '0;
        s0_item.last    = 1'b0;
        s0_item.err     = 1'b0;

        if (in_accept && !r_done && r_cfg_fmt <= lbpu_pkg::FMT_ARGB32
                && width_d != '0 && height_d != '0) begin
            if (r_cfg_fmt == lbpu_pkg::FMT_PALETTE && EW'(r_load_cnt) < entries) begin
                // Collect a palette entry and store it when complete
                need      = r_cfg_alpha ? 3'd4 : 3'd3;
                word_done = phase_inc >= need;
                if (word_done) begin
                    ram_we     = 1'b1;
                    n_load_cnt = r_load_cnt + LCW'(1);
                    n_phase    = '0;
                    n_partial  = '0;
                end else begin
                    n_partial = {r_partial[15:0], b};
                    n_phase   = phase_inc[1:0];
                end
            end else if (r_pad != 2'd0) begin
                // Drop a row padding byte
                n_pad = r_pad - 2'd1;
            end else if (r_cfg_fmt == lbpu_pkg::FMT_PALETTE) begin
                // Look the index up
                n_phase   = '0;
                n_partial = '0;
                pix       = 1'b1;
                if (EW'(b) < entries) begin
                    ram_re          = 1'b1;
                    s0_item.use_ram = 1'b1;
                end else begin
                    s0_item.err = 1'b1;
                end
            end else begin
                // Gather a big-endian word
                need      = (r_cfg_fmt == lbpu_pkg::FMT_RGB555) ? 3'd2 : 3'd4;
                word_done = phase_inc >= need;
                if (word_done) begin
                    n_phase   = '0;
                    n_partial = '0;
                    pix       = 1'b1;
                    s0_item.argb = (r_cfg_fmt == lbpu_pkg::FMT_RGB555)
                                 ? lbpu_pkg::widen_555(full[14:0]) : full;
                end else begin
                    n_partial = {r_partial[15:0], b};
                    n_phase   = phase_inc[1:0];
                end
            end

            // Advance column and row on each pixel
            if (pix) begin
                s0_emit = 1'b1;
                n_col   = col_inc;
                if (col_inc >= width_d || col_inc == '0) begin
                    n_col = '0;
                    if (row_inc >= {1'b0, height_d}) begin
                        s0_item.last = 1'b1;
                        n_done       = 1'b1;
                        n_row        = '0;
                    end else begin
                        n_row = row_inc[DIM_BITS-1:0];
                        if (r_cfg_fmt == lbpu_pkg::FMT_PALETTE) begin
                            n_pad = 2'd0 - width_d[1:0];
                        end else if (r_cfg_fmt == lbpu_pkg::FMT_RGB555) begin
                            n_pad = width_d[0] ? 2'd2 : 2'd0;
                        end
                    end
                end
            end
        end
    end

    // Stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_phase    <= '0;
            r_partial  <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_pad      <= '0;
            r_done     <= 1'b0;
        end else begin
            r_load_cnt <= n_load_cnt;
            r_phase    <= n_phase;
            r_partial  <= n_partial;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pad      <= n_pad;
            r_done     <= n_done;
        end
    end

    // Palette memory
    lbpu_ram #(
        .WIDTH (PW),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Lookup stage: hold the item while the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_s1_valid <= s0_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= s0_item;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_argb <= r_s1.use_ram ? ram_rdata : r_s1.argb;
            r_out_last <= r_s1.last;
            r_out_err  <= r_s1.err;
        end
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_argb  = r_out_argb;
    assign o_pixel.last_pixel  = r_out_last;
    assign o_pixel.index_error = r_out_err;

endmodule

// ----- hdl/lbpu_checker.sv -----
// Port-level assertions for the bitmap pixel unpacker, bound to the top level.
`timescale 1ns / 1ps

module lbpu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lbpu_pkg::PIXEL_W-1:0]  i_out_argb,
    input logic                          i_out_last,
    input logic                          i_out_err
);

    // Hold a stalled pixel
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("pixel dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_argb) && $stable(i_out_last)
            && $stable(i_out_err))
        else $error("pixel changed while stalled");

    // Out-of-range index gives a zero pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> i_out_argb == '0)
        else $error("index error with nonzero pixel");

    // Nothing follows the last pixel
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid)
        else $error("pixel after last pixel");

endmodule

bind lossless_bitmap_pixel_unpacker_top lbpu_checker u_lbpu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pixel.valid),
    .i_out_ready (o_pixel.ready),
    .i_out_argb  (o_pixel.pixel_argb),
    .i_out_last  (o_pixel.last_pixel),
    .i_out_err   (o_pixel.index_error)
);

// ----- bench/lbpu_pixel_checker.sv -----
// Pixel checker: tracks register writes and accepted bytes, predicts pixels and compares them.
`timescale 1ns / 1ps

module lbpu_pixel_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lbpu_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [lbpu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    lbpu_byte_if                            byte_ch,
    lbpu_pixel_if                           pix_ch,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int PAL_DEPTH = lbpu_pkg::PALETTE_DEPTH_DEF;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [lbpu_pkg::PIXEL_W-1:0] argb;
        logic                         last;
        logic                         err;
    } t_pixel;

    // Pixels predicted but not yet seen on the output
    t_pixel pending_pixels[$];

    // Shadow registers
    logic [1:0]                     fmt_r;
    logic                           alpha_r;
    logic [15:0]                    width_r;
    logic [15:0]                    height_r;
    logic [lbpu_pkg::ENTRIES_W-1:0] entries_r;

    // Shadow unpacker state
    logic [lbpu_pkg::PIXEL_W-1:0]   pal_mem [PAL_DEPTH];
    logic [lbpu_pkg::ENTRIES_W-1:0] load_cnt;
    logic [lbpu_pkg::PHASE_W-1:0]   phase;
    logic [lbpu_pkg::PARTIAL_W-1:0] partial;
    logic [15:0]                    col;
    logic [15:0]                    row;
    logic [1:0]                     pad_cnt;
    logic                           img_done;

    t_pixel want;
    t_pixel got_px;

    // Collect bytes of a big-endian word; return 1 with the word once need bytes are in
    function automatic bit gather_word(input logic [7:0] b, input int need,
                                       output logic [31:0] full);
        full = '0;
        if (int'(phase) + 1 >= need) begin
            full = {partial, b};
            if (need == 2)
                full = full & 32'h0000ffff;
            else if (need == 3)
                full = full & 32'h00ffffff;
            phase   = '0;
            partial = '0;
            return 1'b1;
        end
        partial = {partial[15:0], b};
        phase   = phase + 2'd1;
        return 1'b0;
    endfunction

    // Advance the shadow state by one byte; return 1 when it completes a pixel
    function automatic bit unpack_byte(input logic [7:0] b, output t_pixel px);
        int          ent;
        logic [31:0] word;
        px  = '0;
        ent = (int'(entries_r) > PAL_DEPTH) ? PAL_DEPTH : int'(entries_r);
        if (img_done || fmt_r > lbpu_pkg::FMT_ARGB32 || width_r == 16'd0
                || height_r == 16'd0)
            return 1'b0;

        // Load palette entries first
        if (fmt_r == lbpu_pkg::FMT_PALETTE && int'(load_cnt) < ent) begin
            if (gather_word(b, alpha_r ? 4 : 3, word)) begin
                pal_mem[load_cnt[7:0]] = alpha_r ? {word[7:0], word[31:8]}
                                                 : {8'hff, word[23:0]};
                load_cnt = load_cnt + 1'b1;
            end
            return 1'b0;
        end

        // Drop row padding
        if (pad_cnt != 2'd0) begin
            pad_cnt = pad_cnt - 2'd1;
            return 1'b0;
        end

        case (fmt_r)
            lbpu_pkg::FMT_PALETTE: begin
                phase   = '0;
                partial = '0;
                if (int'(b) < ent) begin
                    px.argb = pal_mem[b];
                end else begin
                    px.argb = '0;
                    px.err  = 1'b1;
                end
            end
            lbpu_pkg::FMT_RGB555: begin
                if (!gather_word(b, 2, word))
                    return 1'b0;
                px.argb = {8'hff, word[14:10], word[14:12], word[9:5], word[9:7],
                           word[4:0], word[4:2]};
            end
            default: begin
                if (!gather_word(b, 4, word))
                    return 1'b0;
                px.argb = word;
            end
        endcase

        // Advance column and row; set padding for the next row
        col = col + 16'd1;
        if (col >= width_r || col == 16'd0) begin
            col = '0;
            if (int'(row) + 1 >= int'(height_r)) begin
                px.last  = 1'b1;
                img_done = 1'b1;
                row      = '0;
            end else begin
                row = row + 16'd1;
                if (fmt_r == lbpu_pkg::FMT_PALETTE)
                    pad_cnt = ~width_r[1:0] + 2'd1;
                else if (fmt_r == lbpu_pkg::FMT_RGB555)
                    pad_cnt = width_r[0] ? 2'd2 : 2'd0;
            end
        end
        return 1'b1;
    endfunction

    task automatic log_mismatch(input string msg);
        if (o_fail_count < MAX_SHOWN)
            $display("%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Compare pixels, apply register writes, predict from accepted bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_r     = lbpu_pkg::FMT_PALETTE;
            alpha_r   = 1'b0;
            width_r   = 16'd1;
            height_r  = 16'd1;
            entries_r = 9'd256;
            for (int i = 0; i < PAL_DEPTH; i++)
                pal_mem[i] = '0;
            load_cnt = '0;
            phase    = '0;
            partial  = '0;
            col      = '0;
            row      = '0;
            pad_cnt  = '0;
            img_done = 1'b0;
            pending_pixels.delete();
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (pending_pixels.size() == 0) begin
                    log_mismatch($sformatf("unexpected pixel argb=%h last=%b err=%b",
                                           pix_ch.pixel_argb, pix_ch.last_pixel,
                                           pix_ch.index_error));
                end else begin
                    want = pending_pixels.pop_front();
                    if (pix_ch.pixel_argb !== want.argb || pix_ch.last_pixel !== want.last ||
                        pix_ch.index_error !== want.err)
                        log_mismatch($sformatf(
                            "expected argb=%h last=%b err=%b, got argb=%h last=%b err=%b",
                            want.argb, want.last, want.err, pix_ch.pixel_argb,
                            pix_ch.last_pixel, pix_ch.index_error));
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    lbpu_pkg::CFG_PIXEL_FORMAT:    fmt_r     = i_cfg_wdata[1:0];
                    lbpu_pkg::CFG_ALPHA_PRESENT:   alpha_r   = i_cfg_wdata[0];
                    lbpu_pkg::CFG_IMAGE_WIDTH:     width_r   = i_cfg_wdata[15:0];
                    lbpu_pkg::CFG_IMAGE_HEIGHT:    height_r  = i_cfg_wdata[15:0];
                    lbpu_pkg::CFG_PALETTE_ENTRIES:
                        entries_r = i_cfg_wdata[lbpu_pkg::ENTRIES_W-1:0];
                    default: ;
                endcase
            end

            if (byte_ch.valid && byte_ch.ready) begin
                if (unpack_byte(byte_ch.data_byte, got_px))
                    pending_pixels.push_back(got_px);
            end
        end
        o_pending = pending_pixels.size();
    end

endmodule

// ----- bench/testbench.sv -----
// Testbench top: drives bytes and register writes into the unpacker and gives the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] FMT_UNUSED   = 2'd3;
    localparam int         LIMIT_CYCLES = 500000;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         RANDOM_BYTES = 750;
    localparam int         PAL_DEPTH    = lbpu_pkg::PALETTE_DEPTH_DEF;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [lbpu_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [lbpu_pkg::CFG_DATA_W-1:0] cfg_wdata;

    lbpu_byte_if  byte_ch ();
    lbpu_pixel_if pix_ch ();

    int fail_count;
    int pending;
    int cyc;
    int gap_max;
    int burst_left;
    int loaded;     // palette entries the stimulus has loaded so far

    // Directed bytes: entry 0 opaque white, entry 1 with zero alpha, then indices and a pad
    logic [7:0] b_list_a [14] = '{8'hff, 8'hff, 8'hff, 8'hff,
                                 8'h12, 8'h34, 8'h56, 8'h00,
                                 8'h00, 8'h01, 8'h02, 8'h5a, 8'hff, 8'h01};

    lossless_bitmap_pixel_unpacker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_byte      (byte_ch),
        .o_pixel     (pix_ch)
    );

    lbpu_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .byte_ch      (byte_ch),
        .pix_ch       (pix_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Stall the receiver on a rotating pattern; end the run on timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        case ((cyc / 200) % 4)
            0:       pix_ch.ready <= 1'b1;
            1:       pix_ch.ready <= 1'($urandom_range(0, 1));
            2:       pix_ch.ready <= (cyc % 7) < 4;
            default: pix_ch.ready <= (cyc % 40) >= 25;
        endcase
        if (cyc >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Hold the input idle until every predicted pixel is out and the pipeline is empty
    task automatic wait_drain();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input lbpu_pkg::t_cfg_idx idx,
                             input logic [lbpu_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Drain, then write all registers and pick a pacing for the next phase
    task automatic configure(input logic [1:0] fmt, input logic alpha,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [lbpu_pkg::ENTRIES_W-1:0] ent);
        wait_drain();
        write_reg(lbpu_pkg::CFG_PIXEL_FORMAT, 16'(fmt));
        write_reg(lbpu_pkg::CFG_ALPHA_PRESENT, 16'(alpha));
        write_reg(lbpu_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(lbpu_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(lbpu_pkg::CFG_PALETTE_ENTRIES, 16'(ent));
        cfg_we <= 1'b0;
        case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 2;
            default: gap_max = 8;
        endcase
    endtask

    // Send one item, in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
    endtask

    initial begin
        int          kind;
        int          nbytes;
        int          pause_at;
        int          done_bytes;
        int          w;
        int          ent;
        int          ent_eff;
        logic        alpha;
        logic [7:0]  b;

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_addr          = lbpu_pkg::CFG_PIXEL_FORMAT;
        cfg_wdata         = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        pix_ch.ready      = 1'b0;
        cyc               = 0;
        gap_max           = 0;
        burst_left        = 0;
        loaded            = 0;
        done_bytes        = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Palette with alpha: two entries, in-range and out-of-range indices, row padding
        configure(lbpu_pkg::FMT_PALETTE, 1'b1, 16'd3, 16'hffff, 9'd2);
        foreach (b_list_a[i]) send_byte(b_list_a[i]);
        loaded = 2;

        // Zero entries: every index is out of range
        configure(lbpu_pkg::FMT_PALETTE, 1'b0, 16'd4, 16'hffff, 9'd0);
        send_byte(8'h00);
        send_byte(8'h80);

        // All-ones 15-bit pixel, odd width, then two row padding bytes
        configure(lbpu_pkg::FMT_RGB555, 1'b0, 16'd1, 16'hffff, 9'd0);
        send_byte(8'h7f);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h00);

        // 32-bit word, widest row
        configure(lbpu_pkg::FMT_ARGB32, 1'b0, 16'hffff, 16'hffff, 9'd0);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);

        // Ignored bytes: unused format, zero width, zero height
        configure(FMT_UNUSED, 1'b0, 16'd2, 16'hffff, 9'd256);
        send_byte(8'h55);
        send_byte(8'haa);
        configure(lbpu_pkg::FMT_ARGB32, 1'b0, 16'd0, 16'hffff, 9'd256);
        send_byte(8'h12);
        send_byte(8'h34);
        configure(lbpu_pkg::FMT_RGB555, 1'b0, 16'd5, 16'd0, 9'd256);
        send_byte(8'hc3);
        send_byte(8'h3c);

        // Random phases across formats, widths and entry counts
        while (done_bytes < RANDOM_BYTES) begin
            kind = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0:       w = 1;
                1:       w = 65535;
                default: w = $urandom_range(1, 9);
            endcase
            nbytes   = $urandom_range(16, 64);
            alpha    = 1'($urandom_range(0, 1));
            ent      = $urandom_range(0, 511);
            pause_at = ($urandom_range(0, 3) == 0) ? nbytes / 2 : -1;
            ent_eff  = 0;
            case (kind)
                0, 1, 2: begin
                    case ($urandom_range(0, 7))
                        0:       ent = 0;
                        1:       ent = 511;
                        2:       ent = 300;
                        3:       ent = 256;
                        4:       ent = 1;
                        default: ent = $urandom_range(2, 256);
                    endcase
                    ent_eff = (ent > PAL_DEPTH) ? PAL_DEPTH : ent;
                    configure(lbpu_pkg::FMT_PALETTE, alpha, 16'(w), 16'hffff, 9'(ent));
                    // Load any entries the raised count asks for
                    if (ent_eff > loaded) begin
                        repeat ((ent_eff - loaded) * (alpha ? 4 : 3))
                            send_byte(8'($urandom_range(0, 255)));
                        done_bytes += (ent_eff - loaded) * (alpha ? 4 : 3);
                        loaded = ent_eff;
                    end
                end
                3, 4:    configure(lbpu_pkg::FMT_RGB555, alpha, 16'(w), 16'hffff, 9'(ent));
                5, 6:    configure(lbpu_pkg::FMT_ARGB32, alpha, 16'(w), 16'hffff, 9'(ent));
                default: begin
                    nbytes = $urandom_range(4, 10);
                    case ($urandom_range(0, 2))
                        0:       configure(FMT_UNUSED, alpha, 16'(w), 16'hffff, 9'(ent));
                        1:       configure(lbpu_pkg::FMT_ARGB32, alpha, 16'd0, 16'hffff,
                                           9'(ent));
                        default: configure(lbpu_pkg::FMT_RGB555, alpha, 16'(w), 16'd0,
                                           9'(ent));
                    endcase
                end
            endcase

            for (int i = 0; i < nbytes; i++) begin
                if (i == pause_at)
                    wait_drain();
                if (ent_eff > 0 && $urandom_range(0, 3) != 0)
                    b = 8'($urandom_range(0, ent_eff - 1));
                else
                    b = 8'($urandom_range(0, 255));
                send_byte(b);
            end
            done_bytes += nbytes;
        end

        // Finish the image with a single-row height, then bytes that must be dropped
        configure(lbpu_pkg::FMT_ARGB32, 1'b0, 16'd2, 16'd1, 9'd256);
        repeat (24) send_byte(8'($urandom_range(0, 255)));

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
